/* hw/rtl/safv_pkg.sv */
// shared constants, register indexes, saturation and sign helpers and latency functions for the fold unit
`timescale 1ns / 1ps
package safv_pkg;

  localparam int FRAC_BITS_DEF = 24;
  localparam logic [31:0] MAXV = 32'h7fff_ffff;

  typedef enum logic [2:0] {
    REG_SMOOTH = 3'd0,
    REG_MODE   = 3'd1,
    REG_ADD_X  = 3'd2,
    REG_ADD_Y  = 3'd3,
    REG_ADD_Z  = 3'd4,
    REG_ADD_W  = 3'd5
  } reg_idx_t;

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] res;
    if (v > 36'sh0_7fff_ffff) begin
      res = 32'sh7fff_ffff;
    end else if (v < -36'sh0_8000_0000) begin
      res = -32'sh8000_0000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

  function automatic logic signed [31:0] sign_restore(input logic signed [31:0] r,
                                                      input logic signed [31:0] orig);
    logic signed [31:0] res;
    if (orig == 32'sd0) begin
      res = 32'sd0;
    end else if (orig[31]) begin
      res = -r;
    end else begin
      res = r;
    end
    return res;
  endfunction

  function automatic int root_lat(input int frac);
    return 2 + (((32 + frac) / 2) + 3) / 4;
  endfunction

  function automatic int unit_lat(input int frac);
    return root_lat(frac) + 3 * (root_lat(frac) + 2) + 1;
  endfunction

endpackage

/* hw/rtl/safv_root.sv */
// pipelined smooth root sqrt(v*v + smooth) with sideband
`timescale 1ns / 1ps
module safv_root import safv_pkg::*; #(
  parameter int FRAC = FRAC_BITS_DEF,
  parameter int SW   = 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic signed [31:0] in_v,
  input  logic [30:0]        smooth,
  input  logic [SW-1:0]      in_side,
  output logic               out_valid,
  output logic signed [31:0] out_root,
  output logic [SW-1:0]      out_side
);
  localparam int NP   = (32 + FRAC) / 2;
  localparam int NSTG = (NP + 3) / 4;
  localparam int RW   = 2 * NP;
  localparam int MW   = NP + 3;

  logic               sq_vld_r;
  logic [63:0]        sq_r;
  logic [SW-1:0]      sq_side_r;
  logic [63:0]        sq_sh;
  logic [31:0]        sq_c;
  logic [32:0]        sum;
  logic [30:0]        q_c;

  logic               vld_r  [0:NSTG];
  logic [RW-1:0]      rad_r  [0:NSTG];
  logic [MW-1:0]      rem_r  [0:NSTG];
  logic [NP-1:0]      root_r [0:NSTG];
  logic [SW-1:0]      side_r [0:NSTG];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r <= 1'b0;
    end else begin
      sq_vld_r <= in_valid;
    end
    sq_r      <= 64'(64'(in_v) * 64'(in_v));
    sq_side_r <= in_side;
  end

  always_comb begin
    sq_sh = sq_r >> FRAC;
    sq_c  = (sq_sh > 64'(MAXV)) ? MAXV : sq_sh[31:0];
    sum   = 33'(sq_c) + 33'(smooth);
    q_c   = (sum > 33'(MAXV)) ? MAXV[30:0] : sum[30:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= sq_vld_r;
    end
    rad_r[0]  <= RW'(q_c) << FRAC;
    rem_r[0]  <= '0;
    root_r[0] <= '0;
    side_r[0] <= sq_side_r;
  end

  for (genvar s = 0; s < NSTG; s++) begin : g_stg
    logic [RW-1:0] rad_c;
    logic [MW-1:0] rem_c;
    logic [NP-1:0] root_c;
    logic [MW-1:0] trial;

    always_comb begin
      rad_c  = rad_r[s];
      rem_c  = rem_r[s];
      root_c = root_r[s];
      trial  = '0;
      for (int k = 0; k < 4; k++) begin
        if (s * 4 + k < NP) begin
          rem_c = {rem_c[MW-3:0], rad_c[RW-1 -: 2]};
          rad_c = rad_c << 2;
          trial = MW'({root_c, 2'b01});
          if (rem_c >= trial) begin
            rem_c  = rem_c - trial;
            root_c = {root_c[NP-2:0], 1'b1};
          end else begin
            root_c = {root_c[NP-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else begin
        vld_r[s+1] <= vld_r[s];
      end
      rad_r[s+1]  <= rad_c;
      rem_r[s+1]  <= rem_c;
      root_r[s+1] <= root_c;
      side_r[s+1] <= side_r[s];
    end
  end

  assign out_valid = vld_r[NSTG];
  assign out_side  = side_r[NSTG];
  assign out_root  = (64'(root_r[NSTG]) > 64'(MAXV)) ? signed'(MAXV)
                                                      : signed'(32'(root_r[NSTG]));

endmodule

/* hw/rtl/safv_fold.sv */
// pipelined smooth compare-and-swap fold of one pair
`timescale 1ns / 1ps
module safv_fold import safv_pkg::*; #(
  parameter int FRAC = FRAC_BITS_DEF,
  parameter int SW   = 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_en,
  input  logic signed [31:0] in_a,
  input  logic signed [31:0] in_b,
  input  logic [30:0]        smooth,
  input  logic [SW-1:0]      in_side,
  output logic               out_valid,
  output logic signed [31:0] out_a,
  output logic signed [31:0] out_b,
  output logic [SW-1:0]      out_side
);
  localparam int RSW = SW + 97;

  logic               t_vld_r;
  logic signed [31:0] t_r;
  logic [SW+64:0]     t_side_r;

  logic               r_vld;
  logic signed [31:0] r_root;
  logic [RSW-1:0]     r_side;

  logic signed [31:0] ra, rb, rt;
  logic               ren;
  logic [SW-1:0]      rs;
  logic signed [33:0] d;
  logic signed [33:0] h;

  logic               vld_r;
  logic signed [31:0] a_r, b_r;
  logic [SW-1:0]      side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_vld_r <= 1'b0;
    end else begin
      t_vld_r <= in_valid;
    end
    t_r      <= sat32(36'(in_a) - 36'(in_b));
    t_side_r <= {in_en, in_a, in_b, in_side};
  end

  safv_root #(.FRAC(FRAC), .SW(RSW)) u_root (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (t_vld_r),
    .in_v     (t_r),
    .smooth   (smooth),
    .in_side  ({t_side_r[SW+64 -: 65], t_r, t_side_r[SW-1:0]}),
    .out_valid(r_vld),
    .out_root (r_root),
    .out_side (r_side)
  );

  always_comb begin
    {ren, ra, rb, rt, rs} = r_side;
    d = 34'(rt) - 34'(r_root);
    h = d >>> 1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= r_vld;
    end
    a_r    <= ren ? sat32(36'(ra) - 36'(h)) : ra;
    b_r    <= ren ? sat32(36'(rb) + 36'(h)) : rb;
    side_r <= rs;
  end

  assign out_valid = vld_r;
  assign out_a     = a_r;
  assign out_b     = b_r;
  assign out_side  = side_r;

endmodule

/* hw/rtl/smooth_abs_fold_vector_unit.sv */
// top level: smooth abs of x, y, z, optional sign restore, three folds, offset add
// throughput: one word per cycle, set by the fully pipelined root stages
// busy stays low and the receiver cannot stall; results come on out_valid
// reset clears all valid bits and loads default register values
`timescale 1ns / 1ps
module smooth_abs_fold_vector_unit import safv_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_x,
  input  logic signed [31:0] in_y,
  input  logic signed [31:0] in_z,
  input  logic signed [31:0] in_w,
  output logic               out_valid,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic signed [31:0] out_w,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  logic [30:0]        smooth_r;
  logic [3:0]         mode_r;
  logic signed [31:0] add_x_r, add_y_r, add_z_r, add_w_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smooth_r <= 31'd83886;
      mode_r   <= 4'd14;
      add_x_r  <= '0;
      add_y_r  <= '0;
      add_z_r  <= '0;
      add_w_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SMOOTH: smooth_r <= cfg_data[30:0];
        REG_MODE:   mode_r   <= cfg_data[3:0];
        REG_ADD_X:  add_x_r  <= cfg_data;
        REG_ADD_Y:  add_y_r  <= cfg_data;
        REG_ADD_Z:  add_z_r  <= cfg_data;
        REG_ADD_W:  add_w_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  logic               acc;
  logic               rx_vld;
  logic signed [31:0] rx, ry, rz;
  logic [127:0]       rx_side;
  logic signed [31:0] x0, y0, z0, w0;
  logic signed [31:0] xs, ys, zs;

  assign acc = start && !busy;

  safv_root #(.FRAC(FRAC_BITS), .SW(128)) u_root_x (
    .clk(clk), .rst_n(rst_n), .in_valid(acc), .in_v(in_x), .smooth(smooth_r),
    .in_side({in_x, in_y, in_z, in_w}),
    .out_valid(rx_vld), .out_root(rx), .out_side(rx_side)
  );

  safv_root #(.FRAC(FRAC_BITS), .SW(1)) u_root_y (
    .clk(clk), .rst_n(rst_n), .in_valid(acc), .in_v(in_y), .smooth(smooth_r),
    .in_side(1'b0), .out_valid(), .out_root(ry), .out_side()
  );

  safv_root #(.FRAC(FRAC_BITS), .SW(1)) u_root_z (
    .clk(clk), .rst_n(rst_n), .in_valid(acc), .in_v(in_z), .smooth(smooth_r),
    .in_side(1'b0), .out_valid(), .out_root(rz), .out_side()
  );

  always_comb begin
    {x0, y0, z0, w0} = rx_side;
    xs = mode_r[0] ? sign_restore(rx, x0) : rx;
    ys = mode_r[0] ? sign_restore(ry, y0) : ry;
    zs = mode_r[0] ? sign_restore(rz, z0) : rz;
  end

  // fold xy
  logic               f1_vld;
  logic signed [31:0] f1_x, f1_y;
  logic [63:0]        f1_side;

  safv_fold #(.FRAC(FRAC_BITS), .SW(64)) u_fold_xy (
    .clk(clk), .rst_n(rst_n), .in_valid(rx_vld), .in_en(mode_r[1]),
    .in_a(xs), .in_b(ys), .smooth(smooth_r), .in_side({zs, w0}),
    .out_valid(f1_vld), .out_a(f1_x), .out_b(f1_y), .out_side(f1_side)
  );

  // fold xz
  logic               f2_vld;
  logic signed [31:0] f2_x, f2_z;
  logic [63:0]        f2_side;

  safv_fold #(.FRAC(FRAC_BITS), .SW(64)) u_fold_xz (
    .clk(clk), .rst_n(rst_n), .in_valid(f1_vld), .in_en(mode_r[2]),
    .in_a(f1_x), .in_b(f1_side[63:32]), .smooth(smooth_r),
    .in_side({f1_y, f1_side[31:0]}),
    .out_valid(f2_vld), .out_a(f2_x), .out_b(f2_z), .out_side(f2_side)
  );

  // fold yz
  logic               f3_vld;
  logic signed [31:0] f3_y, f3_z;
  logic [63:0]        f3_side;

  safv_fold #(.FRAC(FRAC_BITS), .SW(64)) u_fold_yz (
    .clk(clk), .rst_n(rst_n), .in_valid(f2_vld), .in_en(mode_r[3]),
    .in_a(f2_side[63:32]), .in_b(f2_z), .smooth(smooth_r),
    .in_side({f2_x, f2_side[31:0]}),
    .out_valid(f3_vld), .out_a(f3_y), .out_b(f3_z), .out_side(f3_side)
  );

  logic               out_valid_r;
  logic signed [31:0] out_x_r, out_y_r, out_z_r, out_w_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= f3_vld;
    end
    out_x_r <= sat32(36'(signed'(f3_side[63:32])) + 36'(add_x_r));
    out_y_r <= sat32(36'(f3_y) + 36'(add_y_r));
    out_z_r <= sat32(36'(f3_z) + 36'(add_z_r));
    out_w_r <= sat32(36'(signed'(f3_side[31:0])) + 36'(add_w_r));
  end

  assign out_valid = out_valid_r;
  assign out_x     = out_x_r;
  assign out_y     = out_y_r;
  assign out_z     = out_z_r;
  assign out_w     = out_w_r;

endmodule

/* hw/rtl/safv_checker.sv */
// port-level checker for the fold unit and its bind
`timescale 1ns / 1ps
module safv_checker import safv_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic cfg_ready
);
  localparam int LAT = unit_lat(FRAC_BITS);

  a_lat_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("accepted word produced no result");

  a_lat_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && rst_n, LAT))
    else $error("result without matching accepted word");

  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result right after reset");

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !busy && cfg_ready)
    else $error("unit refused a word");

endmodule

bind smooth_abs_fold_vector_unit safv_checker #(.FRAC_BITS(FRAC_BITS)) u_safv_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .cfg_ready(cfg_ready)
);
